// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the TGA pixel stream decoder RTL.
// The bodies are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every rising clock edge outside reset.
`define TPSD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define TPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TPSD_ASSERT(label, clk, rst_n, prop, msg)
`define TPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/tpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants of the TGA pixel stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tpsd_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_COMPRESSED  = 2'd0;
  localparam logic [1:0] REG_DEPTH_CODE  = 2'd1;
  localparam logic [1:0] REG_PIXEL_TOTAL = 2'd2;

  // Depth codes.
  localparam logic [1:0] DEPTH_16 = 2'd0;
  localparam logic [1:0] DEPTH_24 = 2'd1;
  localparam logic [1:0] DEPTH_32 = 2'd2;

  // Reset values of the configuration registers.
  localparam logic        RST_COMPRESSED  = 1'b0;
  localparam logic [1:0]  RST_DEPTH_CODE  = DEPTH_24;
  localparam logic [31:0] RST_PIXEL_TOTAL = 32'd65536;

  // One assembled pixel with its clamped repeat count.
  typedef struct packed {
    logic [31:0] pix_bytes;
    logic [7:0]  count;
    logic        last;
  } pix_t;

  // Configuration as seen by the front and back parts.
  typedef struct packed {
    logic        compressed;
    logic [1:0]  depth_code;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/tga_pixel_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder
// TGA pixel data decoder: raw and RLE packets to RGBA results with counts.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the pixel-data bytes of a TGA image (after the header) on the input
//   channel, one byte per transfer (in_valid_i / in_stall_o / data_byte_i).
//   Each completed pixel, or each RLE run, leaves as one transfer on the
//   output channel with red/green/blue/alpha, repeat_count and last_pixel.
//   Program compressed, depth_code and pixel_total over the APB port while
//   the block is idle; a write to any defined register restarts decoding of a new image.
//   Once pixel_total pixels have been produced, further bytes are taken and
//   dropped without results.
// Timing:
//   One byte is taken per cycle while the pixel queue is not full. A completed
//   pixel is written into the pixel queue and from there loaded into the
//   output register. The byte front end carries all packet state and updates
//   it for each accepted byte, so that update sets the rate.
// Reset and stall:
//   Reset loads compressed=0, 24-bit depth and a total of 65536 pixels, and
//   empties the queue. A stalled output holds its result; the queue absorbs
//   the next pixels and in_stall_o rises only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_pixel_stream_decoder #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // byte input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       alpha_o,
  output logic [7:0]       repeat_count_o,
  output logic             last_pixel_o
);
  import tpsd_pkg::*;

  logic        compressed_q;
  logic [1:0]  depth_code_q;
  logic [31:0] pixel_total_q;
  logic        wr_en;
  logic [1:0]  reg_idx;
  logic        restart;
  logic [31:0] restart_total;
  cfg_t        cfg;

  logic        in_accept;
  logic        push;
  pix_t        push_item;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  pix_t        q_item;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Restart on a write to any defined register.
  always_comb begin
    restart       = 1'b0;
    restart_total = pixel_total_q;
    case (reg_idx)
      REG_COMPRESSED:  restart = wr_en;
      REG_DEPTH_CODE:  restart = wr_en;
      REG_PIXEL_TOTAL: begin
        restart       = wr_en;
        restart_total = wr_en ? pwdata : pixel_total_q;
      end
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compressed_q  <= RST_COMPRESSED;
      depth_code_q  <= RST_DEPTH_CODE;
      pixel_total_q <= RST_PIXEL_TOTAL;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COMPRESSED:  compressed_q  <= pwdata[0];
        REG_DEPTH_CODE:  depth_code_q  <= pwdata[1:0];
        REG_PIXEL_TOTAL: pixel_total_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COMPRESSED:  prdata = {31'b0, compressed_q};
      REG_DEPTH_CODE:  prdata = {30'b0, depth_code_q};
      REG_PIXEL_TOTAL: prdata = pixel_total_q;
      default:         prdata = 32'b0;
    endcase
  end

  assign cfg.compressed = compressed_q;
  assign cfg.depth_code = depth_code_q;

  // Hold the input off only while the pixel queue is full.
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  tpsd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .restart_i       (restart),
    .restart_total_i (restart_total),
    .accept_i        (in_accept),
    .data_byte_i     (data_byte_i),
    .push_o          (push),
    .item_o          (push_item)
  );

  tpsd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_item)
  );

  tpsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_data_i       (q_item),
    .pop_o          (q_pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .repeat_count_o (repeat_count_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

`default_nettype wire

// ===== rtl/tpsd_front.sv =====
// ----------------------------------------------------------------------------
// tpsd_front
// Byte front end: packet header parsing, pixel assembly, pixel budget.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tpsd_pkg::cfg_t cfg_i,
  input  wire logic          restart_i,
  input  wire logic [31:0]   restart_total_i,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  output logic               push_o,
  output tpsd_pkg::pix_t     item_o
);
  import tpsd_pkg::*;

  typedef enum logic [2:0] {
    KIND_HDR = 3'b001,
    KIND_RAW = 3'b010,
    KIND_RUN = 3'b100
  } kind_e;

  kind_e       kind_q, kind_d;
  logic [31:0] pixel_q, pixel_d;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  left_q, left_d;
  logic [31:0] remaining_q, remaining_d;

  logic [1:0]  bpp_mod;
  logic [1:0]  idx_nxt;
  logic        complete;
  logic [31:0] merged;
  logic [7:0]  em_cnt;
  logic [7:0]  cnt;
  logic [31:0] rem_new;
  logic [7:0]  left_dec;
  logic        live;

  always_comb begin
    case (cfg_i.depth_code)
      DEPTH_16: bpp_mod = 2'd2;
      DEPTH_32: bpp_mod = 2'd0;
      default:  bpp_mod = 2'd3;
    endcase
  end

  assign idx_nxt  = idx_q + 2'd1;
  assign complete = (idx_nxt == bpp_mod);
  assign merged   = pixel_q | ({24'b0, data_byte_i} << {idx_q, 3'b000});
  assign live     = accept_i && (remaining_q != 32'd0);

  // Clamp the repeat count to what is left of the image.
  assign em_cnt  = (cfg_i.compressed && kind_q == KIND_RUN) ? left_q : 8'd1;
  assign cnt     = ({24'b0, em_cnt} > remaining_q) ? remaining_q[7:0] : em_cnt;
  assign rem_new = remaining_q - {24'b0, cnt};
  assign left_dec = left_q - 8'd1;

  assign item_o.pix_bytes = merged;
  assign item_o.count     = cnt;
  assign item_o.last      = (rem_new == 32'd0);

  always_comb begin
    kind_d      = kind_q;
    pixel_d     = pixel_q;
    idx_d       = idx_q;
    left_d      = left_q;
    remaining_d = remaining_q;
    push_o      = 1'b0;
    if (restart_i) begin
      kind_d      = KIND_HDR;
      pixel_d     = '0;
      idx_d       = '0;
      left_d      = '0;
      remaining_d = restart_total_i;
    end else if (live) begin
      if (cfg_i.compressed && kind_q == KIND_HDR) begin
        // Start a packet: literal below 128, run otherwise.
        kind_d  = data_byte_i[7] ? KIND_RUN : KIND_RAW;
        left_d  = data_byte_i[7] ? (data_byte_i - 8'd127) : (data_byte_i + 8'd1);
        pixel_d = '0;
        idx_d   = '0;
      end else if (complete) begin
        push_o      = 1'b1;
        pixel_d     = '0;
        idx_d       = '0;
        remaining_d = rem_new;
        if (cfg_i.compressed) begin
          if (kind_q == KIND_RUN) begin
            left_d = '0;
            kind_d = KIND_HDR;
          end else begin
            left_d = left_dec;
            if (left_dec == 8'd0) begin
              kind_d = KIND_HDR;
            end
          end
        end
      end else begin
        pixel_d = merged;
        idx_d   = idx_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_HDR;
      pixel_q     <= '0;
      idx_q       <= '0;
      left_q      <= '0;
      remaining_q <= RST_PIXEL_TOTAL;
    end else begin
      kind_q      <= kind_d;
      pixel_q     <= pixel_d;
      idx_q       <= idx_d;
      left_q      <= left_d;
      remaining_q <= remaining_d;
    end
  end

`include "assert_macros.svh"

  `TPSD_ASSERT_NEXT(a_last_empties, clk_i, rst_ni, push_o && item_o.last && !restart_i, remaining_q == 32'd0, "last result left pixels remaining")
  `TPSD_ASSERT(a_push_count, clk_i, rst_ni, !push_o || item_o.count != 8'd0, "zero repeat count pushed")

endmodule

`default_nettype wire

// ===== rtl/tpsd_fifo.sv =====
// ----------------------------------------------------------------------------
// tpsd_fifo
// Short queue of assembled pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tpsd_pkg::pix_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output tpsd_pkg::pix_t      data_o
);
  import tpsd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pix_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? ((wr_q == PTR_LAST) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? ((rd_q == PTR_LAST) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`include "assert_macros.svh"

  `TPSD_ASSERT(a_no_overflow, clk_i, rst_ni, !push_i || !full_o, "push into full queue")
  `TPSD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_FULL, "queue count out of range")

endmodule

`default_nettype wire

// ===== rtl/tpsd_back.sv =====
// ----------------------------------------------------------------------------
// tpsd_back
// Color unpacking and output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tpsd_pkg::cfg_t cfg_i,
  input  wire logic           q_valid_i,
  input  wire tpsd_pkg::pix_t q_data_i,
  output logic                pop_o,
  input  wire logic           out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [7:0]          alpha_o,
  output logic [7:0]          repeat_count_o,
  output logic                last_pixel_o
);
  import tpsd_pkg::*;

  logic        valid_q, valid_d;
  logic [7:0]  red_q, green_q, blue_q, alpha_q, cnt_q;
  logic        last_q;
  logic [7:0]  red_d, green_d, blue_d, alpha_d;
  logic [31:0] v;

  assign v = q_data_i.pix_bytes;

  // Load a new result whenever the output register is free or drains now.
  assign pop_o = q_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    alpha_d = 8'd0;
    if (cfg_i.depth_code == DEPTH_16) begin
      blue_d  = {v[4:0],   3'b000};
      green_d = {v[9:5],   3'b000};
      red_d   = {v[14:10], 3'b000};
    end else begin
      blue_d  = v[7:0];
      green_d = v[15:8];
      red_d   = v[23:16];
      if (cfg_i.depth_code == DEPTH_32) begin
        alpha_d = v[31:24];
      end
    end
  end

  always_comb begin
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
      cnt_q   <= q_data_i.count;
      last_q  <= q_data_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign alpha_o        = alpha_q;
  assign repeat_count_o = cnt_q;
  assign last_pixel_o   = last_q;

`include "assert_macros.svh"

  `TPSD_ASSERT(a_out_count, clk_i, rst_ni, !valid_q || cnt_q != 8'd0, "result with zero repeat count")

endmodule

`default_nettype wire
